// File: hw/rtl/ffh_pkg.sv
// ----------------------------------------------------------------------------
// ffh_pkg
// Shared widths and the sideband record of the face flux pipeline.
// ----------------------------------------------------------------------------
package ffh_pkg;
  localparam int QF       = 16;
  localparam int CW       = 31;
  localparam int EW       = 32;
  localparam int TW       = 32;
  localparam int SUMW     = TW + 1;
  localparam int PW       = 2 * TW;
  localparam int MW       = TW + 1;
  localparam int DMW      = EW + 1;
  localparam int FMW      = CW + DMW - QF;
  localparam logic [CW-1:0] COND_MAX = {CW{1'b1}};

  typedef struct packed {
    logic           interior;
    logic [CW-1:0]  fw;
    logic [CW-1:0]  gap;
    logic           neg;
    logic [DMW-1:0] dmag;
  } side_t;

  localparam int SIDEW = $bits(side_t);
endpackage

// File: hw/rtl/ffh_div.sv
// ----------------------------------------------------------------------------
// ffh_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ffh_div
  import ffh_pkg::*;
#(
  parameter int DW = SUMW,
  parameter int QW = TW,
  parameter int SW = SIDEW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_vld,
  input  logic [DW-1:0] in_den,
  input  logic [DW-1:0] in_rem,
  input  logic [QW-1:0] in_low,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [DW-1:0] out_den,
  output logic [DW-1:0] out_rem,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_side
);
  logic          vld  [0:QW];
  logic [DW-1:0] den  [0:QW];
  logic [DW-1:0] rem  [0:QW];
  logic [QW-1:0] low  [0:QW];
  logic [SW-1:0] side [0:QW];

  assign vld[0]  = in_vld;
  assign den[0]  = in_den;
  assign rem[0]  = in_rem;
  assign low[0]  = in_low;
  assign side[0] = in_side;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          vld_r;
    logic [DW-1:0] den_r;
    logic [DW-1:0] rem_r;
    logic [QW-1:0] low_r;
    logic [SW-1:0] side_r;
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_nxt;
    logic [DW:0]   diff;

    assign trial   = {rem[k], low[k][QW-1]};
    assign ge      = trial >= {1'b0, den[k]};
    assign diff    = trial - {1'b0, den[k]};
    assign rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (adv) begin
        vld_r <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        den_r  <= den[k];
        rem_r  <= rem_nxt;
        low_r  <= {low[k][QW-2:0], ge};
        side_r <= side[k];
      end
    end

    assign vld[k+1]  = vld_r;
    assign den[k+1]  = den_r;
    assign rem[k+1]  = rem_r;
    assign low[k+1]  = low_r;
    assign side[k+1] = side_r;
  end

  assign out_vld  = vld[QW];
  assign out_den  = den[QW];
  assign out_rem  = rem[QW];
  assign out_quo  = low[QW];
  assign out_side = side[QW];
endmodule

// File: hw/rtl/ffh_front.sv
// ----------------------------------------------------------------------------
// ffh_front
// Thickness, cell transmissivities, their sum and product.
// ----------------------------------------------------------------------------
module ffh_front
  import ffh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  in_vld,
  input  logic                  interior_face,
  input  logic [CW-1:0]         cond_first,
  input  logic signed [EW-1:0]  top_first,
  input  logic signed [EW-1:0]  base_first,
  input  logic signed [EW-1:0]  head_first,
  input  logic [CW-1:0]         cond_second,
  input  logic signed [EW-1:0]  top_second,
  input  logic signed [EW-1:0]  base_second,
  input  logic signed [EW-1:0]  head_second,
  input  logic [CW-1:0]         face_width,
  input  logic [CW-1:0]         centre_gap,
  output logic                  out_vld,
  output logic [PW-1:0]         out_prod,
  output logic [SUMW-1:0]       out_sum,
  output side_t                 out_side
);
  logic [EW:0]     d1, d2, dh, dneg;
  logic            s1_vld_r, s2_vld_r, s3_vld_r;
  logic [EW-1:0]   b1_r, b2_r;
  logic [CW-1:0]   c1_r, c2_r;
  side_t           s1_side_r, s2_side_r, s3_side_r, side_nxt;
  logic [CW+EW-1:0] p1, p2;
  logic [TW-1:0]   ta_r, tb_r;
  logic [PW-1:0]   prod_r;
  logic [SUMW-1:0] sum_r;

  assign d1   = {top_first[EW-1], top_first} - {base_first[EW-1], base_first};
  assign d2   = {top_second[EW-1], top_second} - {base_second[EW-1], base_second};
  assign dh   = {head_second[EW-1], head_second} - {head_first[EW-1], head_first};
  assign dneg = -dh;

  always_comb begin
    side_nxt.interior = interior_face;
    side_nxt.fw       = face_width;
    side_nxt.gap      = centre_gap;
    side_nxt.neg      = dh[EW];
    side_nxt.dmag     = dh[EW] ? dneg : dh;
  end

  assign p1 = c1_r * b1_r;
  assign p2 = c2_r * b2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_r      <= d1[EW] ? '0 : d1[EW-1:0];
      b2_r      <= d2[EW] ? '0 : d2[EW-1:0];
      c1_r      <= cond_first;
      c2_r      <= cond_second;
      s1_side_r <= side_nxt;
      ta_r      <= (|p1[CW+EW-1:QF+TW]) ? '1 : p1[QF+TW-1:QF];
      tb_r      <= (|p2[CW+EW-1:QF+TW]) ? '1 : p2[QF+TW-1:QF];
      s2_side_r <= s1_side_r;
      prod_r    <= ta_r * tb_r;
      sum_r     <= {1'b0, ta_r} + {1'b0, tb_r};
      s3_side_r <= s2_side_r;
    end
  end

  assign out_vld  = s3_vld_r;
  assign out_prod = prod_r;
  assign out_sum  = sum_r;
  assign out_side = s3_side_r;
endmodule

// File: hw/rtl/ffh_back.sv
// ----------------------------------------------------------------------------
// ffh_back
// Conductance select, flux product, saturation and the output register.
// ----------------------------------------------------------------------------
module ffh_back
  import ffh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_vld,
  input  logic                 in_sat,
  input  logic [CW-1:0]        in_quo,
  input  side_t                in_side,
  output logic                 out_vld,
  output logic [CW-1:0]        out_cond,
  output logic signed [EW-1:0] out_flux
);
  logic            c_vld_r, f_vld_r, o_vld_r;
  logic [CW-1:0]   c_r, cf_r, co_r;
  side_t           c_side_r;
  logic            f_int_r, f_neg_r;
  logic [FMW-1:0]  fmag_r;
  logic [CW+DMW-1:0] prod;
  logic [EW:0]     mag;
  logic [EW:0]     negmag;
  logic [EW-1:0]   flux_nxt, flux_r;

  assign prod = c_r * c_side_r.dmag;

  always_comb begin
    if (f_neg_r) begin
      mag = (fmag_r > FMW'({1'b1, {(EW-1){1'b0}}})) ? {2'b01, {(EW-1){1'b0}}}
                                                    : fmag_r[EW:0];
    end else begin
      mag = (fmag_r > FMW'(COND_MAX)) ? {2'b00, COND_MAX} : fmag_r[EW:0];
    end
    negmag   = -mag;
    flux_nxt = f_neg_r ? negmag[EW-1:0] : mag[EW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= in_vld;
      f_vld_r <= c_vld_r;
      o_vld_r <= f_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_r      <= in_sat ? COND_MAX : in_quo;
      c_side_r <= in_side;
      fmag_r   <= prod[CW+DMW-1:QF];
      cf_r     <= c_r;
      f_int_r  <= c_side_r.interior;
      f_neg_r  <= c_side_r.neg;
      co_r     <= f_int_r ? cf_r : '0;
      flux_r   <= f_int_r ? flux_nxt : '0;
    end
  end

  assign out_vld  = o_vld_r;
  assign out_cond = co_r;
  assign out_flux = flux_r;
endmodule

// File: hw/rtl/fv_face_flux_harmonic.sv
// ----------------------------------------------------------------------------
// fv_face_flux_harmonic
// Face conductance and Darcy flux from harmonic-mean transmissivity.
// ----------------------------------------------------------------------------
//   channel | ports                               | direction
//   in      | in_valid, in_stall, in_<field>      | faces in
//   out     | out_valid, out_stall, out_<field>   | results out
//
// One face per cycle sustained while out_stall is low; faces pass through the front,
// the mean divider, the m, n and v registers, the conductance divider and the back.
// Synchronous active-low reset clears the valid bits only.
// A stalled result holds the whole pipeline; nothing is dropped or repeated.
module fv_face_flux_harmonic
  import ffh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_interior_face,
  input  logic [CW-1:0]        in_cond_first,
  input  logic signed [EW-1:0] in_top_first,
  input  logic signed [EW-1:0] in_base_first,
  input  logic signed [EW-1:0] in_head_first,
  input  logic [CW-1:0]        in_cond_second,
  input  logic signed [EW-1:0] in_top_second,
  input  logic signed [EW-1:0] in_base_second,
  input  logic signed [EW-1:0] in_head_second,
  input  logic [CW-1:0]        in_face_width,
  input  logic [CW-1:0]        in_centre_gap,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CW-1:0]        out_conductance,
  output logic signed [EW-1:0] out_flux
);
  logic            adv;
  logic            f_vld;
  logic [PW-1:0]   f_prod;
  logic [SUMW-1:0] f_sum;
  side_t           f_side;
  logic            d1_vld;
  logic [SUMW-1:0] d1_den, d1_rem;
  logic [TW-1:0]   d1_quo;
  logic [SIDEW-1:0] d1_side;
  logic            m_vld_r, n_vld_r, v_vld_r;
  logic [MW-1:0]   m_r;
  side_t           m_side_r, n_side_r, v_side_r;
  logic [PW-1:0]   num_r;
  logic [PW-1:0]   vnum_r;
  logic            sat;
  logic [MW:0]     m_nxt;
  logic            ovf;
  logic            d2_vld;
  logic [CW-1:0]   d2_den, d2_rem, d2_quo;
  logic [SIDEW-1:0] d2_side;
  logic            d2_side_sat;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  ffh_front u_front (
    .clk, .rst_n, .adv,
    .in_vld        (in_valid),
    .interior_face (in_interior_face),
    .cond_first    (in_cond_first),
    .top_first     (in_top_first),
    .base_first    (in_base_first),
    .head_first    (in_head_first),
    .cond_second   (in_cond_second),
    .top_second    (in_top_second),
    .base_second   (in_base_second),
    .head_second   (in_head_second),
    .face_width    (in_face_width),
    .centre_gap    (in_centre_gap),
    .out_vld       (f_vld),
    .out_prod      (f_prod),
    .out_sum       (f_sum),
    .out_side      (f_side)
  );

  ffh_div #(.DW(SUMW), .QW(TW), .SW(SIDEW)) u_div_mean (
    .clk, .rst_n, .adv,
    .in_vld   (f_vld),
    .in_den   (f_sum),
    .in_rem   ({1'b0, f_prod[PW-1:TW]}),
    .in_low   (f_prod[TW-1:0]),
    .in_side  (f_side),
    .out_vld  (d1_vld),
    .out_den  (d1_den),
    .out_rem  (d1_rem),
    .out_quo  (d1_quo),
    .out_side (d1_side)
  );

  assign m_nxt = {1'b0, d1_quo, 1'b0}
               + (MW+1)'({d1_rem, 1'b0} >= {1'b0, d1_den});
  assign ovf   = vnum_r[PW-1:CW] >= {{(PW-2*CW){1'b0}}, v_side_r.gap};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
      n_vld_r <= 1'b0;
      v_vld_r <= 1'b0;
    end else if (adv) begin
      m_vld_r <= d1_vld;
      n_vld_r <= m_vld_r;
      v_vld_r <= n_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_r      <= (d1_den == '0) ? '0 : m_nxt[MW-1:0];
      m_side_r <= side_t'(d1_side);
      num_r    <= PW'(m_r * m_side_r.fw);
      n_side_r <= m_side_r;
      vnum_r   <= num_r;
      v_side_r <= n_side_r;
    end
  end

  always_comb begin
    sat = ovf && (vnum_r != '0);
  end

  ffh_div #(.DW(CW), .QW(CW), .SW(SIDEW + 1)) u_div_cond (
    .clk, .rst_n, .adv,
    .in_vld   (v_vld_r),
    .in_den   (v_side_r.gap),
    .in_rem   (ovf ? '0 : vnum_r[2*CW-1:CW]),
    .in_low   (ovf ? '0 : vnum_r[CW-1:0]),
    .in_side  ({sat, v_side_r}),
    .out_vld  (d2_vld),
    .out_den  (d2_den),
    .out_rem  (d2_rem),
    .out_quo  (d2_quo),
    .out_side ({d2_side_sat, d2_side})
  );

  ffh_back u_back (
    .clk, .rst_n, .adv,
    .in_vld   (d2_vld),
    .in_sat   (d2_side_sat),
    .in_quo   ((d2_den == '0) ? '0 : d2_quo),
    .in_side  (side_t'(d2_side)),
    .out_vld  (out_valid),
    .out_cond (out_conductance),
    .out_flux (out_flux)
  );
endmodule

// File: bench/fv_face_flux_harmonic_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fv_face_flux_harmonic_tb
// Streams mesh faces into the flux block under several idle and stall
// patterns, predicts conductance and flux per face in fixed point and
// compares every result in order.
// ----------------------------------------------------------------------------
module fv_face_flux_harmonic_tb;
  import ffh_pkg::*;

  typedef struct {
    bit              interior;
    bit [CW-1:0]     cond_a;
    bit [EW-1:0]     top_a;
    bit [EW-1:0]     base_a;
    bit [EW-1:0]     head_a;
    bit [CW-1:0]     cond_b;
    bit [EW-1:0]     top_b;
    bit [EW-1:0]     base_b;
    bit [EW-1:0]     head_b;
    bit [CW-1:0]     width;
    bit [CW-1:0]     gap;
  } face_t;

  typedef struct {
    bit [CW-1:0] conductance;
    bit [EW-1:0] flux;
  } face_flux_t;

  int errors = 0;

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  function automatic bit [TW:0] cell_trans(bit [CW-1:0] k, bit [EW-1:0] top,
                                           bit [EW-1:0] base);
    logic signed [EW:0] d;
    bit [127:0] p;
    d = $signed({top[EW-1], top}) - $signed({base[EW-1], base});
    if (d <= 0) return 0;
    p = (128'(k) * 128'(d)) >> QF;
    return (p > 128'hFFFF_FFFF) ? 33'hFFFF_FFFF : p[TW:0];
  endfunction

  function automatic face_flux_t face_predict(face_t f);
    face_flux_t r;
    bit [127:0] ta, tb, s, x, q, rm, m, num, c, fm;
    logic signed [EW+1:0] dh;
    bit neg;
    bit [EW:0] dmag;
    r.conductance = 0;
    r.flux = 0;
    if (!f.interior) return r;
    ta = cell_trans(f.cond_a, f.top_a, f.base_a);
    tb = cell_trans(f.cond_b, f.top_b, f.base_b);
    s = ta + tb;
    if (s == 0) m = 0;
    else begin
      x = ta * tb;
      q = x / s;
      rm = x % s;
      m = 2 * q + ((2 * rm >= s) ? 1 : 0);
    end
    num = m * f.width;
    if (f.gap == 0) c = (num == 0) ? 0 : 128'h7FFF_FFFF;
    else c = num / f.gap;
    if (c > 128'h7FFF_FFFF) c = 128'h7FFF_FFFF;
    r.conductance = c[CW-1:0];
    dh = $signed({{2{f.head_b[EW-1]}}, f.head_b}) - $signed({{2{f.head_a[EW-1]}}, f.head_a});
    neg = dh < 0;
    dmag = neg ? -dh : dh;
    fm = (c * dmag) >> QF;
    if (neg) begin
      if (fm > 128'h8000_0000) fm = 128'h8000_0000;
      r.flux = -fm[EW-1:0];
    end else begin
      if (fm > 128'h7FFF_FFFF) fm = 128'h7FFF_FFFF;
      r.flux = fm[EW-1:0];
    end
    return r;
  endfunction

  class flux_scoreboard;
    face_flux_t pending[$];
    function void note_face(face_t f);
      pending.push_back(face_predict(f));
    endfunction
    task check_result(bit [CW-1:0] cond, bit [EW-1:0] flux);
      face_flux_t e;
      if (pending.size() == 0) begin
        report("unexpected result", cond, 0);
        return;
      end
      e = pending.pop_front();
      if (cond !== e.conductance) report("conductance", cond, e.conductance);
      if (flux !== e.flux) report("flux", flux, e.flux);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic in_interior_face = 0;
  logic [CW-1:0] in_cond_first = 0, in_cond_second = 0, in_face_width = 0;
  logic [CW-1:0] in_centre_gap = 1;
  logic signed [EW-1:0] in_top_first = 0, in_base_first = 0, in_head_first = 0;
  logic signed [EW-1:0] in_top_second = 0, in_base_second = 0, in_head_second = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [CW-1:0] out_conductance;
  logic signed [EW-1:0] out_flux;

  fv_face_flux_harmonic dut (.*);

  always #4 clk = ~clk;

  flux_scoreboard faces = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  localparam int WATCHDOG = 5000;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) faces.check_result(out_conductance, out_flux);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("** fv_face_flux_harmonic: FAILED **");
        $finish;
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic bit [EW-1:0] rnd_elev();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(200000) - 100000;
      2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  function automatic bit [CW-1:0] rnd_pos();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(1 << 20);
      2: return $urandom_range(1) ? 31'h7FFF_FFFF : 31'h0;
      default: return 31'h10000 + $urandom_range(1 << 16);
    endcase
  endfunction

  function automatic face_t rnd_face();
    face_t f;
    f.interior = ($urandom_range(9) != 0);
    f.cond_a = rnd_pos();
    f.cond_b = rnd_pos();
    f.top_a = rnd_elev();
    f.base_a = ($urandom_range(3) == 0) ? rnd_elev() : f.top_a - $urandom_range(1 << 22);
    f.top_b = rnd_elev();
    f.base_b = ($urandom_range(3) == 0) ? rnd_elev() : f.top_b - $urandom_range(1 << 22);
    f.head_a = rnd_elev();
    f.head_b = rnd_elev();
    f.width = rnd_pos();
    f.gap = rnd_pos();
    if (f.gap == 0 && $urandom_range(1)) f.gap = 1;
    return f;
  endfunction

  task automatic send_face(face_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_interior_face <= f.interior;
    in_cond_first <= f.cond_a;
    in_top_first <= f.top_a;
    in_base_first <= f.base_a;
    in_head_first <= f.head_a;
    in_cond_second <= f.cond_b;
    in_top_second <= f.top_b;
    in_base_second <= f.base_b;
    in_head_second <= f.head_b;
    in_face_width <= f.width;
    in_centre_gap <= f.gap;
    do @(posedge clk); while (in_stall);
    faces.note_face(f);
  endtask

  task automatic send_directed();
    face_t f;
    for (int i = 0; i < 22; i++) begin
      f = rnd_face();
      f.interior = 1;
      case (i)
        0: f.interior = 0;
        1: begin f.top_a = 0; f.base_a = 32'h10000; end
        2: begin f.top_a = f.base_a; f.top_b = f.base_b; end
        3: begin f.cond_a = 0; f.cond_b = 0; end
        4: f.gap = 0;
        5: begin f.gap = 0; f.width = 0; end
        6: f.gap = 1;
        7: begin f.cond_a = '1; f.cond_b = '1; f.top_a = 32'h7FFF_FFFF;
                 f.base_a = 32'h8000_0000; f.top_b = 32'h7FFF_FFFF;
                 f.base_b = 32'h8000_0000; f.width = '1; f.gap = 1;
                 f.head_a = 32'h8000_0000; f.head_b = 32'h7FFF_FFFF; end
        8: begin f.cond_a = '1; f.cond_b = '1; f.top_a = 32'h7FFF_FFFF;
                 f.base_a = 32'h8000_0000; f.top_b = 32'h7FFF_FFFF;
                 f.base_b = 32'h8000_0000; f.width = '1; f.gap = 1;
                 f.head_a = 32'h7FFF_FFFF; f.head_b = 32'h8000_0000; end
        9: f.head_b = f.head_a;
        10: f.width = 0;
        11: begin f.cond_a = 31'h10000; f.top_a = 32'h20000; f.base_a = 0;
                  f.cond_b = 31'h10000; f.top_b = 32'h20000; f.base_b = 0;
                  f.width = 31'h10000; f.gap = 31'h10000;
                  f.head_a = 0; f.head_b = 32'h10000; end
        12: begin f.interior = 0; f.cond_a = '1; f.gap = 0; end
        default: ;
      endcase
      send_face(f);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_directed();
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 31 : 62) : 0;
      recv_stall_pct = (phase == 2) ? 62 : (phase == 3 ? 31 : 0);
      for (int i = 0; i < 320; i++) send_face(rnd_face());
    end
    in_valid <= 0;
    recv_stall_pct = 0;
    while (faces.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && faces.pending.size() == 0) begin
      $display("** fv_face_flux_harmonic: PASSED **");
    end else begin
      $display("** fv_face_flux_harmonic: FAILED **");
    end
    $finish;
  end
endmodule
